// ===== rtl/tqe_pkg.sv =====
package tqe_pkg;

    localparam int MAX_OUT = 32;

    typedef enum logic [2:0] {
        CMD_ADD        = 3'd0,
        CMD_CANCEL_ONE = 3'd1,
        CMD_CANCEL_ALL = 3'd2,
        CMD_TICK       = 3'd3,
        CMD_CHECK      = 3'd4
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NONE_DUE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] owner;
        logic [7:0]  callback_id;
        logic [30:0] delay_ms;
        logic [4:0]  handle;
        logic [15:0] elapsed_ms;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [15:0] expired_owner;
        logic [7:0]  expired_callback;
        logic [5:0]  removed_count;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [15:0]        owner;
        logic [7:0]         callback;
        logic signed [31:0] remaining;
        logic [15:0]        stamp;
    } entry_t;

    typedef struct packed {
        logic               owner_match;
        logic               due;
        logic               better;
        logic signed [31:0] tick_rem;
        logic [15:0]        age;
    } eval_t;

endpackage

// ===== rtl/tqe_ram.sv =====
module tqe_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tqe_slot_eval.sv =====
module tqe_slot_eval (
    input  tqe_pkg::entry_t    entry,
    input  logic [15:0]        owner,
    input  logic [15:0]        elapsed_ms,
    input  logic [15:0]        stamp,
    input  logic               best_v,
    input  logic signed [31:0] best_rem,
    input  logic [15:0]        best_age,
    output tqe_pkg::eval_t     result
);

    logic signed [32:0] diff;

    always_comb
    begin
        diff = {entry.remaining[31], entry.remaining} - $signed({17'd0, elapsed_ms});
        result.owner_match = (entry.owner == owner);
        result.due         = (entry.remaining <= 32'sd0);
        result.age         = stamp - entry.stamp;
        // saturate at the lowest signed value
        if (diff[32] != diff[31])
        begin
            result.tick_rem = 32'sh8000_0000;
        end
        else
        begin
            result.tick_rem = diff[31:0];
        end
        // newer timer wins a tie on deadline
        result.better = !best_v || (entry.remaining < best_rem) ||
                        ((entry.remaining == best_rem) && (result.age < best_age));
    end

endmodule

// ===== rtl/timeout_queue_engine.sv =====
// Timer table engine: holds SLOTS software timers, one command per transfer.
// Command channel cmd_valid/cmd_stall/cmd_data; result channel
// rsp_valid/rsp_stall/rsp_data. Every command yields one result with last
// set, except check, which yields one result per expired timer (deadline
// order, newer first on a tie, up to 32) or a single "nothing expired".
// Timer fields live in one synchronous RAM; the valid bits are flip-flops.
// Cancel-one reads only the slot its handle names. Add, cancel-all and
// tick walk the RAM one slot per cycle. Check runs one full walk per
// expired timer plus a final one.
// A new command is taken only when the previous one has finished; its last
// result may still sit in the output register. A stalled receiver holds the
// result register and pauses the engine when it has another result to give.
// Reset clears all valid bits, the age stamp counter and both channels; no
// clearing pass over the RAM is needed.
module timeout_queue_engine #(
    parameter int SLOTS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  tqe_pkg::cmd_t cmd_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tqe_pkg::rsp_t rsp_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int ENTRY_W = $bits(tqe_pkg::entry_t);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_TAIL  = 5'b00100,
        S_DONE  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    tqe_pkg::cmd_t      cmd_reg, cmd_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               proc_v_reg, proc_v_next;
    logic [IDX_W-1:0]   proc_idx_reg, proc_idx_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [15:0]        stamp_reg, stamp_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               best_v_reg, best_v_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic signed [31:0] best_rem_reg, best_rem_next;
    logic [15:0]        best_age_reg, best_age_next;
    logic [15:0]        best_owner_reg, best_owner_next;
    logic [7:0]         best_cb_reg, best_cb_next;
    logic               pend_v_reg, pend_v_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [15:0]        pend_owner_reg, pend_owner_next;
    logic [7:0]         pend_cb_reg, pend_cb_next;
    logic [5:0]         k_reg, k_next;
    logic               rsp_valid_reg, rsp_valid_next;
    tqe_pkg::rsp_t      rsp_data_reg, rsp_data_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    tqe_pkg::entry_t    ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    tqe_pkg::entry_t    ram_rdata;
    tqe_pkg::eval_t     ev;
    logic               can_push;
    logic               cmd_xfer;
    logic [IDX_W-1:0]   handle_idx;
    logic               handle_ok;
    logic               proc_slot_v;
    tqe_pkg::rsp_t      pend_rsp;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_xfer   = cmd_valid && !cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;
    assign can_push   = !rsp_valid_reg || !rsp_stall;
    assign handle_idx = IDX_W'(cmd_data.handle);
    assign handle_ok  = (32'(cmd_data.handle) < SLOTS);
    assign ram_raddr  = (state_reg == S_IDLE) ? handle_idx : rd_idx_reg;
    assign proc_slot_v = valid_reg[proc_idx_reg];

    tqe_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    tqe_slot_eval u_eval (
        .entry     (ram_rdata),
        .owner     (cmd_reg.owner),
        .elapsed_ms(cmd_reg.elapsed_ms),
        .stamp     (stamp_reg),
        .best_v    (best_v_reg),
        .best_rem  (best_rem_reg),
        .best_age  (best_age_reg),
        .result    (ev)
    );

    always_comb
    begin
        pend_rsp                  = '0;
        pend_rsp.status           = tqe_pkg::ST_OK;
        pend_rsp.slot             = 5'(pend_idx_reg);
        pend_rsp.expired_owner    = pend_owner_reg;
        pend_rsp.expired_callback = pend_cb_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        rd_idx_next     = rd_idx_reg;
        proc_v_next     = 1'b0;
        proc_idx_next   = proc_idx_reg;
        valid_next      = valid_reg;
        stamp_next      = stamp_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        cnt_next        = cnt_reg;
        best_v_next     = best_v_reg;
        best_idx_next   = best_idx_reg;
        best_rem_next   = best_rem_reg;
        best_age_next   = best_age_reg;
        best_owner_next = best_owner_reg;
        best_cb_next    = best_cb_reg;
        pend_v_next     = pend_v_reg;
        pend_idx_next   = pend_idx_reg;
        pend_owner_next = pend_owner_reg;
        pend_cb_next    = pend_cb_reg;
        k_next          = k_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_data_next   = rsp_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = proc_idx_reg;
        ram_wdata       = ram_rdata;

        // process stage: RAM data for proc_idx_reg is on ram_rdata
        if (proc_v_reg)
        begin
            unique case (cmd_reg.cmd)
                tqe_pkg::CMD_ADD:
                begin
                    if (!proc_slot_v && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = proc_idx_reg;
                    end
                end
                tqe_pkg::CMD_CANCEL_ONE:
                begin
                    if (proc_slot_v && ev.owner_match)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                        hit_next                 = 1'b1;
                    end
                end
                tqe_pkg::CMD_CANCEL_ALL:
                begin
                    if (proc_slot_v && ev.owner_match)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                        if (cnt_reg != 6'd63)
                        begin
                            cnt_next = cnt_reg + 6'd1;
                        end
                    end
                end
                tqe_pkg::CMD_TICK:
                begin
                    // write-back trails the read by one slot, never the same entry
                    if (proc_slot_v)
                    begin
                        ram_we              = 1'b1;
                        ram_wdata.remaining = ev.tick_rem;
                    end
                end
                tqe_pkg::CMD_CHECK:
                begin
                    if (proc_slot_v && ev.due && ev.better)
                    begin
                        best_v_next     = 1'b1;
                        best_idx_next   = proc_idx_reg;
                        best_rem_next   = ram_rdata.remaining;
                        best_age_next   = ev.age;
                        best_owner_next = ram_rdata.owner;
                        best_cb_next    = ram_rdata.callback;
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    cmd_next    = cmd_data;
                    hit_next    = 1'b0;
                    cnt_next    = '0;
                    best_v_next = 1'b0;
                    pend_v_next = 1'b0;
                    k_next      = '0;
                    rd_idx_next = '0;
                    if (cmd_data.cmd == tqe_pkg::CMD_CANCEL_ONE)
                    begin
                        proc_v_next   = handle_ok;
                        proc_idx_next = handle_idx;
                        state_next    = S_TAIL;
                    end
                    else if (cmd_data.cmd > tqe_pkg::CMD_CHECK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                proc_v_next   = 1'b1;
                proc_idx_next = rd_idx_reg;
                rd_idx_next   = rd_idx_reg + 1'b1;
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (cmd_reg.cmd == tqe_pkg::CMD_CHECK)
                begin
                    if (best_v_reg)
                    begin
                        if (!pend_v_reg || can_push)
                        begin
                            if (pend_v_reg)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_data_next  = pend_rsp;
                            end
                            pend_v_next              = 1'b1;
                            pend_idx_next            = best_idx_reg;
                            pend_owner_next          = best_owner_reg;
                            pend_cb_next             = best_cb_reg;
                            valid_next[best_idx_reg] = 1'b0;
                            k_next                   = k_reg + 6'd1;
                            best_v_next              = 1'b0;
                            rd_idx_next              = '0;
                            if (k_reg + 6'd1 == 6'(tqe_pkg::MAX_OUT))
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                    end
                    else if (can_push)
                    begin
                        rsp_valid_next = 1'b1;
                        if (pend_v_reg)
                        begin
                            rsp_data_next      = pend_rsp;
                            rsp_data_next.last = 1'b1;
                        end
                        else
                        begin
                            rsp_data_next        = '0;
                            rsp_data_next.status = tqe_pkg::ST_NONE_DUE;
                            rsp_data_next.last   = 1'b1;
                        end
                        pend_v_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
                else if (can_push)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_data_next      = '0;
                    rsp_data_next.last = 1'b1;
                    state_next         = S_IDLE;
                    unique case (cmd_reg.cmd)
                        tqe_pkg::CMD_ADD:
                        begin
                            if (hit_reg)
                            begin
                                ram_we                  = 1'b1;
                                ram_waddr               = hit_idx_reg;
                                ram_wdata.owner         = cmd_reg.owner;
                                ram_wdata.callback      = cmd_reg.callback_id;
                                ram_wdata.remaining     = $signed({1'b0, cmd_reg.delay_ms});
                                ram_wdata.stamp         = stamp_reg;
                                valid_next[hit_idx_reg] = 1'b1;
                                stamp_next              = stamp_reg + 16'd1;
                                rsp_data_next.slot      = 5'(hit_idx_reg);
                            end
                            else
                            begin
                                rsp_data_next.status = tqe_pkg::ST_FULL;
                            end
                        end
                        tqe_pkg::CMD_CANCEL_ONE:
                        begin
                            rsp_data_next.slot   = cmd_reg.handle;
                            rsp_data_next.status = hit_reg ? tqe_pkg::ST_OK
                                                           : tqe_pkg::ST_NOT_FOUND;
                        end
                        tqe_pkg::CMD_CANCEL_ALL:
                        begin
                            rsp_data_next.removed_count = cnt_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FLUSH:
            begin
                if (can_push)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_data_next      = pend_rsp;
                    rsp_data_next.last = 1'b1;
                    pend_v_next        = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            proc_v_reg    <= 1'b0;
            valid_reg     <= '0;
            stamp_reg     <= '0;
            best_v_reg    <= 1'b0;
            pend_v_reg    <= 1'b0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            proc_v_reg    <= proc_v_next;
            valid_reg     <= valid_next;
            stamp_reg     <= stamp_next;
            best_v_reg    <= best_v_next;
            pend_v_reg    <= pend_v_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        rd_idx_reg     <= rd_idx_next;
        proc_idx_reg   <= proc_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        cnt_reg        <= cnt_next;
        best_idx_reg   <= best_idx_next;
        best_rem_reg   <= best_rem_next;
        best_age_reg   <= best_age_next;
        best_owner_reg <= best_owner_next;
        best_cb_reg    <= best_cb_next;
        pend_idx_reg   <= pend_idx_next;
        pend_owner_reg <= pend_owner_next;
        pend_cb_reg    <= pend_cb_next;
        rsp_data_reg   <= rsp_data_next;
    end

    a_mid_rsp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !rsp_data.last) |-> (rsp_data.status == tqe_pkg::ST_OK))
        else $error("non-final result without ok status");

    a_proc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        proc_v_reg |-> (state_reg != S_IDLE))
        else $error("slot processed while idle");

    a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && cmd_reg.cmd == tqe_pkg::CMD_ADD && hit_reg && can_push)
        |=> valid_reg[$past(hit_idx_reg)])
        else $error("added slot not marked valid");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= 6'(tqe_pkg::MAX_OUT))
        else $error("expiry count overrun");

endmodule
